// ===== src/itw_pkg.sv =====
// itw_pkg: widths, division constants, word token codes and the group digit
// types shared by the integer to word tokens block
// depends on nothing
`timescale 1ns / 1ps

package itw_pkg;

  localparam int unsigned ValueW    = 31;
  localparam int unsigned TokenW    = 5;
  localparam int unsigned MaxTokens = 16;

  // group boundaries
  localparam logic [30:0] TwoBillion  = 31'd2000000000;
  localparam logic [30:0] OneBillion  = 31'd1000000000;
  localparam logic [29:0] OneMillion  = 30'd1000000;
  localparam logic [19:0] OneThousand = 20'd1000;

  // reciprocals for the quotient estimates, floor(2^shift / divisor)
  localparam logic [20:0] RecipMillion       = 21'd1099511;
  localparam int unsigned RecipMillionShift  = 40;
  localparam logic [20:0] RecipThousand      = 21'd1073741;
  localparam int unsigned RecipThousandShift = 30;

  // word token codes
  localparam logic [TokenW-1:0] TokZero       = 5'd0;
  localparam logic [TokenW-1:0] TokTen        = 5'd10;
  localparam logic [TokenW-1:0] TokTensOffset = 5'd18;
  localparam logic [TokenW-1:0] TokHundred    = 5'd28;
  localparam logic [TokenW-1:0] TokThousand   = 5'd29;
  localparam logic [TokenW-1:0] TokMillion    = 5'd30;
  localparam logic [TokenW-1:0] TokBillion    = 5'd31;

  // decimal digits of one group of three
  typedef struct packed {
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] u;
  } digits_t;

  typedef struct packed {
    logic [1:0] billions;
    digits_t    millions;
    digits_t    thousands;
    digits_t    units;
  } groups_t;

endpackage

// ===== src/integer_to_word_tokens_top.sv =====
// integer_to_word_tokens_top: spells a 31-bit number as English word tokens
// holds the token sequencer and result register; depends on itw_pkg and itw_split
`timescale 1ns / 1ps

// A number is taken when start is high and busy is low, and comes back as a
// run of word tokens, one per cycle on word_token_o with word_valid_o high
// for exactly that cycle and last_word_o high on the final one; the receiver
// cannot hold tokens off, so each token must be taken as it appears. With
// the block empty an item passes the digit pipeline, the slot registers and
// the result register before its first token appears, and it then holds the
// token output for one token per word, 1 for zero up to 16. An eight-stage
// digit pipeline sits in front of the token sequencer, so items keep being
// taken every cycle while an earlier one is still being spelt; busy rises
// once that pipeline is full and the sequencer has not yet reached the last
// token of the item it is spelling. The runs of consecutive items follow
// each other with no gap. Bits above the 31 of value_i do not exist.

module integer_to_word_tokens_top import itw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ValueW-1:0] value_i,
  output logic              word_valid_o,
  output logic [TokenW-1:0] word_token_o,
  output logic              last_word_o
);

  // five word slots per group: digit, hundred, tens or teens, units, scale;
  // the units group has no scale, so its fifth slot carries the lone zero
  localparam int unsigned SlotsPerGroup = 5;
  localparam int unsigned NumSlots      = 4 * SlotsPerGroup;
  localparam int unsigned SlotIdxW      = $clog2(NumSlots);
  localparam int unsigned ZeroSlot      = NumSlots - 1;

  typedef struct packed {
    logic [SlotsPerGroup-1:0]             mask;
    logic [SlotsPerGroup-1:0][TokenW-1:0] tok;
  } gslot_t;

  // words of one group of three digits, scale word appended when nonzero
  function automatic gslot_t group_slots(digits_t d, logic [TokenW-1:0] scale,
                                         logic has_scale);
    gslot_t s;
    logic   has_h;
    logic   has_tail;
    has_h    = (d.h != 4'd0);
    has_tail = (d.t != 4'd0) || (d.u != 4'd0);
    s.mask[0] = has_h;
    s.tok[0]  = {1'b0, d.h};
    s.mask[1] = has_h;
    s.tok[1]  = TokHundred;
    s.mask[2] = has_tail;
    if (d.t >= 4'd2) begin
      s.tok[2] = TokTensOffset + {1'b0, d.t};
    end else if (d.t == 4'd1) begin
      s.tok[2] = TokTen + {1'b0, d.u};
    end else begin
      s.tok[2] = {1'b0, d.u};
    end
    s.mask[3] = (d.t >= 4'd2) && (d.u != 4'd0);
    s.tok[3]  = {1'b0, d.u};
    s.mask[4] = (has_h || has_tail) && has_scale;
    s.tok[4]  = scale;
    return s;
  endfunction

  // digit pipeline
  logic    grp_valid, grp_ready, split_ready;
  groups_t grp;

  itw_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .in_ready_o  (split_ready),
    .value_i     (value_i),
    .out_valid_o (grp_valid),
    .out_ready_i (grp_ready),
    .groups_o    (grp)
  );

  assign busy = ~split_ready;

  // slot words for a fresh item, billions first
  digits_t [3:0]             grp_dig;
  logic    [3:0][TokenW-1:0] grp_scale;
  logic    [3:0]             grp_has_scale;
  gslot_t  [3:0]             gs;

  assign grp_dig[0]       = '{h: 4'd0, t: 4'd0, u: {2'b00, grp.billions}};
  assign grp_dig[1]       = grp.millions;
  assign grp_dig[2]       = grp.thousands;
  assign grp_dig[3]       = grp.units;
  assign grp_scale        = {TokZero, TokThousand, TokMillion, TokBillion};
  assign grp_has_scale    = 4'b0111;

  logic [NumSlots-1:0]             raw_mask, new_mask;
  logic [NumSlots-1:0][TokenW-1:0] raw_tok, new_tok;

  for (genvar g = 0; g < 4; g++) begin : g_slots
    assign gs[g] = group_slots(grp_dig[g], grp_scale[g], grp_has_scale[g]);
    assign raw_mask[g*SlotsPerGroup +: SlotsPerGroup] = gs[g].mask;
    assign raw_tok[g*SlotsPerGroup +: SlotsPerGroup]  = gs[g].tok;
  end

  // zero spells as the single word zero
  always_comb begin
    new_mask           = raw_mask;
    new_tok            = raw_tok;
    new_mask[ZeroSlot] = (raw_mask[ZeroSlot-1:0] == '0);
    new_tok[ZeroSlot]  = TokZero;
  end

  // token sequencer: walks the pending slots lowest first
  logic [NumSlots-1:0]             mask_q, mask_d, rest_mask;
  logic [NumSlots-1:0][TokenW-1:0] tok_q;
  logic [SlotIdxW-1:0]             pick;
  logic                            emitting, last_tok, load;

  always_comb begin
    pick = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) pick = SlotIdxW'(i);
    end
  end

  assign rest_mask = mask_q & (mask_q - NumSlots'(1));
  assign emitting  = |mask_q;
  assign last_tok  = (rest_mask == '0);
  // a new item may enter while the last word of the current one goes out
  assign grp_ready = ~emitting | last_tok;
  assign load      = grp_valid & grp_ready;
  assign mask_d    = load ? new_mask : rest_mask;

  // result register
  logic              word_valid_q, word_valid_d;
  logic [TokenW-1:0] word_token_q, word_token_d;
  logic              last_word_q, last_word_d;

  assign word_valid_d = emitting;
  assign word_token_d = tok_q[pick];
  assign last_word_d  = last_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      word_valid_q <= 1'b0;
    end else begin
      mask_q       <= mask_d;
      word_valid_q <= word_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) tok_q <= new_tok;
    word_token_q <= word_token_d;
    last_word_q  <= last_word_d;
  end

  assign word_valid_o = word_valid_q;
  assign word_token_o = word_token_q;
  assign last_word_o  = last_word_q;

  // words of one item leave in an unbroken run
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid_q && !last_word_q) |=> word_valid_q)
    else $error("token run broken before its last word");

  // every item loaded has at least one word
  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (mask_q != '0))
    else $error("item loaded with no words");

  // no spelling is longer than the longest number allows
  a_max_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mask_q) <= MaxTokens)
    else $error("too many pending words");

  // an idle sequencer gives no strobe
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !emitting |=> !word_valid_q)
    else $error("strobe without a pending word");

endmodule

// ===== src/itw_split.sv =====
// itw_split: elastic pipeline that splits a 31-bit value into its billion
// digit and the decimal digits of its million, thousand and unit groups
// depends on itw_pkg
`timescale 1ns / 1ps

module itw_split import itw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output groups_t           groups_o
);

  localparam int unsigned NumStages = 8;

  function automatic logic [3:0] hundreds_of(logic [9:0] g);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k <= 9; k++) begin
      if (g >= 10'(k * 100)) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic [3:0] tens_of(logic [6:0] r);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 7'(k * 10)) n = n + 4'd1;
    end
    return n;
  endfunction

  // stage handshake
  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages:0]   adv;

  assign adv[NumStages] = out_ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_adv
    assign adv[k] = ~valid_q[k] | adv[k+1];
  end

  assign valid_d = (adv[NumStages-1:0] & {valid_q[NumStages-2:0], in_valid_i})
                 | (~adv[NumStages-1:0] & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage payloads
  logic [30:0]      val_q;
  logic [1:0]       bil1_q, bil2_q, bil3_q, bil4_q, bil5_q, bil6_q;
  logic [29:0]      rem1_q, rem2_q;
  logic [9:0]       qm2_q, mil3_q, mil4_q, mil5_q, qt4_q, tho5_q, uni5_q;
  logic [19:0]      rem3_q, rem4_q;
  logic [2:0][3:0]  hund6_q;
  logic [2:0][6:0]  rest6_q;
  groups_t          groups_q;

  // billion digit by compare and subtract
  logic [1:0]  bil1_d;
  logic [29:0] rem1_d;
  always_comb begin
    if (val_q >= TwoBillion) begin
      bil1_d = 2'd2;
      rem1_d = 30'(val_q - TwoBillion);
    end else if (val_q >= OneBillion) begin
      bil1_d = 2'd1;
      rem1_d = 30'(val_q - OneBillion);
    end else begin
      bil1_d = 2'd0;
      rem1_d = val_q[29:0];
    end
  end

  // million quotient estimate, low by at most one
  logic [50:0] prod_m;
  logic [9:0]  qm2_d;
  assign prod_m = 51'(rem1_q) * 51'(RecipMillion);
  assign qm2_d  = prod_m[RecipMillionShift +: 10];

  // million correction
  logic [29:0] mm_prod, mm_rem;
  logic [9:0]  mil3_d;
  logic [19:0] rem3_d;
  assign mm_prod = 30'(qm2_q) * OneMillion;
  assign mm_rem  = rem2_q - mm_prod;
  always_comb begin
    if (mm_rem >= OneMillion) begin
      mil3_d = qm2_q + 10'd1;
      rem3_d = 20'(mm_rem - OneMillion);
    end else begin
      mil3_d = qm2_q;
      rem3_d = mm_rem[19:0];
    end
  end

  // thousand quotient estimate, low by at most one
  logic [40:0] prod_t;
  logic [9:0]  qt4_d;
  assign prod_t = 41'(rem3_q) * 41'(RecipThousand);
  assign qt4_d  = prod_t[RecipThousandShift +: 10];

  // thousand correction
  logic [19:0] tt_prod, tt_rem;
  logic [9:0]  tho5_d, uni5_d;
  assign tt_prod = 20'(qt4_q) * OneThousand;
  assign tt_rem  = rem4_q - tt_prod;
  always_comb begin
    if (tt_rem >= OneThousand) begin
      tho5_d = qt4_q + 10'd1;
      uni5_d = 10'(tt_rem - OneThousand);
    end else begin
      tho5_d = qt4_q;
      uni5_d = tt_rem[9:0];
    end
  end

  // hundreds digit of each group, then tens and units
  logic [2:0][9:0] grp5;
  logic [2:0][3:0] hund6_d;
  logic [2:0][6:0] rest6_d;
  logic [2:0][3:0] tens7, unit7;
  assign grp5 = {mil5_q, tho5_q, uni5_q};
  for (genvar g = 0; g < 3; g++) begin : g_digits
    assign hund6_d[g] = hundreds_of(grp5[g]);
    assign rest6_d[g] = 7'(grp5[g] - 10'(hund6_d[g]) * 10'd100);
    assign tens7[g]   = tens_of(rest6_q[g]);
    assign unit7[g]   = 4'(rest6_q[g] - 7'(tens7[g]) * 7'd10);
  end

  groups_t groups_d;
  always_comb begin
    groups_d.billions  = bil6_q;
    groups_d.millions  = '{h: hund6_q[2], t: tens7[2], u: unit7[2]};
    groups_d.thousands = '{h: hund6_q[1], t: tens7[1], u: unit7[1]};
    groups_d.units     = '{h: hund6_q[0], t: tens7[0], u: unit7[0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) val_q <= value_i;
    if (adv[1]) begin
      bil1_q <= bil1_d;
      rem1_q <= rem1_d;
    end
    if (adv[2]) begin
      bil2_q <= bil1_q;
      rem2_q <= rem1_q;
      qm2_q  <= qm2_d;
    end
    if (adv[3]) begin
      bil3_q <= bil2_q;
      mil3_q <= mil3_d;
      rem3_q <= rem3_d;
    end
    if (adv[4]) begin
      bil4_q <= bil3_q;
      mil4_q <= mil3_q;
      rem4_q <= rem3_q;
      qt4_q  <= qt4_d;
    end
    if (adv[5]) begin
      bil5_q <= bil4_q;
      mil5_q <= mil4_q;
      tho5_q <= tho5_d;
      uni5_q <= uni5_d;
    end
    if (adv[6]) begin
      bil6_q  <= bil5_q;
      hund6_q <= hund6_d;
      rest6_q <= rest6_d;
    end
    if (adv[7]) groups_q <= groups_d;
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign groups_o    = groups_q;

endmodule
